[rtl/core/bt36_pkg.sv]
// Shared types and constants for the byte to 36-bit word packer.
// No dependencies; imported by bt36_pack_step and the top level.
package bt36_pkg;

  localparam int unsigned WordW     = 36;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned CharBits  = 7;
  localparam int unsigned TextSlots = 5;
  localparam int unsigned RawSlots  = 8;
  localparam int unsigned TopShift  = 29;

  localparam logic [7:0] TextMax = 8'o177;
  localparam logic [6:0] PadChar = 7'o003;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Register index of the mode register on the configuration port.
  localparam logic REG_RAW_MODE = 1'b0;

  typedef struct packed {
    logic [WordW-1:0] acc;
    logic [SlotW-1:0] slot;
    logic             drop;
  } pack_state_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
    logic [1:0]       status;
  } pack_result_t;

  localparam pack_state_t PackClear = '{acc: '0, slot: '0, drop: 1'b0};

endpackage

[rtl/core/bt36_pack_step.sv]
// Per-byte packing logic: next packing state and optional result for one byte.
// Depends on bt36_pkg.
module bt36_pack_step (
  input  bt36_pkg::pack_state_t  state_i,
  input  logic                   raw_mode_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   is_last_i,
  output bt36_pkg::pack_state_t  state_nxt_o,
  output logic                   res_valid_o,
  output bt36_pkg::pack_result_t result_o
);
  import bt36_pkg::*;

  logic [WordW-1:0] raw_acc;
  logic [WordW-1:0] text_acc;
  logic [WordW-1:0] text_pad;
  logic [WordW-1:0] byte_ext;
  logic [WordW-1:0] char_ext;
  logic [WordW-1:0] pad_ext;
  logic [SlotW-1:0] tk;

  assign byte_ext = {{(WordW-8){1'b0}}, data_byte_i};
  assign char_ext = {{(WordW-7){1'b0}}, data_byte_i[6:0]};
  assign pad_ext  = {{(WordW-7){1'b0}}, PadChar};

  // A slot count beyond the text range restarts at the first slot.
  assign tk = (state_i.slot >= SlotW'(TextSlots)) ? '0 : state_i.slot;

  always_comb begin
    raw_acc  = state_i.acc | (byte_ext << (8 * state_i.slot));
    text_acc = state_i.acc | (char_ext << (TopShift - CharBits * tk));
    text_pad = text_acc;
    for (int j = 0; j < TextSlots; j++) begin
      if (SlotW'(j) > tk) begin
        text_pad = text_pad | (pad_ext << (TopShift - CharBits * j));
      end
    end
  end

  always_comb begin
    state_nxt_o = state_i;
    res_valid_o = 1'b0;
    result_o    = '{word: '0, last: 1'b1, status: ST_OK};
    if (state_i.drop) begin
      if (is_last_i) begin
        state_nxt_o = PackClear;
      end
    end else if (raw_mode_i) begin
      if (state_i.slot == SlotW'(RawSlots - 1)) begin
        res_valid_o = 1'b1;
        result_o    = '{word: raw_acc, last: is_last_i, status: ST_OK};
        state_nxt_o = PackClear;
      end else if (is_last_i) begin
        res_valid_o = 1'b1;
        result_o    = '{word: '0, last: 1'b1, status: ST_BAD_LEN};
        state_nxt_o = PackClear;
      end else begin
        state_nxt_o.acc  = raw_acc;
        state_nxt_o.slot = state_i.slot + 1'b1;
      end
    end else if (data_byte_i > TextMax) begin
      res_valid_o = 1'b1;
      result_o    = '{word: '0, last: 1'b1, status: ST_BAD_CHAR};
      state_nxt_o = PackClear;
      state_nxt_o.drop = ~is_last_i;
    end else if (tk == SlotW'(TextSlots - 1)) begin
      res_valid_o = 1'b1;
      result_o    = '{word: text_acc, last: is_last_i, status: ST_OK};
      state_nxt_o = PackClear;
    end else if (is_last_i) begin
      res_valid_o = 1'b1;
      result_o    = '{word: text_pad, last: 1'b1, status: ST_OK};
      state_nxt_o = PackClear;
    end else begin
      state_nxt_o.acc  = text_acc;
      state_nxt_o.slot = tk + 1'b1;
    end
  end

endmodule

[rtl/core/byte_to_36bit_word_packer.sv]
// Top level of the byte to 36-bit word packer: handshakes, mode register and output buffering.
// Depends on bt36_pkg and bt36_pack_step.
// A result is registered in the output register, or in the skid register during a stall.
// Throughput: one byte request per cycle while the skid register is empty.
// Reset: synchronous, active low; clears the mode (text) and the packing state, and empties
// both output registers.
module byte_to_36bit_word_packer (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] out_word,
  output logic        out_word_last,
  output logic [1:0]  out_status,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bt36_pkg::*;

  logic         raw_mode_r;
  pack_state_t  state_r, state_nxt;
  logic         res_valid;
  pack_result_t result;

  // The output register feeds the port; the skid register catches a result that
  // arrives while the output register is held by a stall on the result side.
  logic         out_valid_r, out_valid_nxt;
  pack_result_t out_r, out_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  pack_result_t skid_r, skid_nxt;

  logic in_fire;
  logic out_pop;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RAW_MODE);
  assign prdata    = (paddr[2] == REG_RAW_MODE) ? {31'b0, raw_mode_r} : 32'b0;

  // A byte request is only refused while the skid register is occupied, so a
  // byte that completes no word still flows while a result waits at the port.
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_pop  = out_valid_r && !out_stall;

  bt36_pack_step u_step (
    .state_i     (state_r),
    .raw_mode_i  (raw_mode_r),
    .data_byte_i (in_data_byte),
    .is_last_i   (in_is_last_byte),
    .state_nxt_o (state_nxt),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  // Output buffering. When the output register frees up it takes the older
  // skid entry first, so results leave in the order they were made.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = in_fire && res_valid;
        skid_nxt       = result;
      end else begin
        out_valid_nxt = in_fire && res_valid;
        out_nxt       = result;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r   <= 1'b0;
      state_r      <= PackClear;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_write) begin
        // Any write of the mode starts a fresh file.
        raw_mode_r <= pwdata[0];
        state_r    <= PackClear;
      end else if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Result payload needs no reset; it is qualified by the valid flags.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_r.word;
  assign out_word_last = out_r.last;
  assign out_status    = out_r.status;

endmodule
